@@ rtl/core/mdt_pkg.sv @@
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types, register codes and table builders for the modulation,
// distortion and tremolo core.
// ----------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

  localparam int TAB_W        = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int INC_W        = 31;
  localparam int DRIVE_GAIN_W = 25;

  localparam logic [CFG_ADDR_W-1:0] REG_MOD_PHASE_INC   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOD_TYPE        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_ENABLE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_GAIN      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DIST_TYPE       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_PHASE_INC = 3'd5;

  localparam logic [DRIVE_GAIN_W-1:0] DRIVE_GAIN_RST = 25'd65536;

  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] EINV_Q30    = 64'sd395007542;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lane_en_t;

  typedef struct packed {
    logic                    mod_type;
    logic                    drive_en;
    logic                    dist_type;
    logic [DRIVE_GAIN_W-1:0] drive_gain;
  } lane_cfg_t;

  // shift-subtract divide, used only while building tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [63:0] quarter_sine(input logic [63:0] k, input int bits);
    logic [63:0]        qn;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 n;
    qn = 64'd1 << (bits - 2);
    if (k == 64'd0) return 64'sd0;
    if (k >= qn) return ONE_Q30;
    x    = (k * HALF_PI_Q30 + (qn >> 1)) >> (bits - 2);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    sum  = $signed(x);
    term = x;
    for (n = 1; n <= 10; n++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 64'sd0) sum = 64'sd0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic logic signed [TAB_W-1:0] sine_entry(input int idx, input int bits);
    logic [63:0]        qn;
    logic [63:0]        quad;
    logic [63:0]        r;
    logic signed [63:0] v;
    qn   = 64'd1 << (bits - 2);
    quad = 64'(idx) >> (bits - 2);
    r    = 64'(idx) & (qn - 64'd1);
    v    = quad[0] ? quarter_sine(qn - r, bits) : quarter_sine(r, bits);
    if (quad[1]) v = -v;
    return v[TAB_W-1:0];
  endfunction

  // tanh(y/2) with y in Q30
  function automatic logic [63:0] tanh_half(input logic [63:0] y);
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [63:0] e;
    int                 i;
    n    = y >> 30;
    f    = y & 64'(ONE_Q30 - 64'sd1);
    term = 64'(ONE_Q30);
    e    = ONE_Q30;
    for (i = 1; i <= 14; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      if ((i & 1) == 1) e = e - $signed(term);
      else e = e + $signed(term);
    end
    for (i = 0; i < 64; i++) begin
      if (64'(i) < n) e = (e * EINV_Q30 + (64'sd1 <<< 29)) >>> 30;
    end
    if (e < 64'sd0) e = 64'sd0;
    if (e > ONE_Q30) e = ONE_Q30;
    num = $unsigned(ONE_Q30 - e) << 30;
    den = $unsigned(ONE_Q30 + e);
    return udiv64(num + (den >> 1), den);
  endfunction

  function automatic logic signed [TAB_W-1:0] tanh_entry(input int idx, input int bits);
    logic [63:0] v;
    v = tanh_half(64'(idx) << (34 - bits));
    return $signed(v[TAB_W-1:0]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/modulation_distortion_tremolo_core.sv @@
// ----------------------------------------------------------------------------
// modulation_distortion_tremolo_core
// Stereo amplitude or ring modulation, drive with tanh or hard clip, and
// tremolo, on signed fixed-point sample pairs.
// ----------------------------------------------------------------------------
// Each word on the input stream is one stereo pair; each output word is the
// processed pair, saturated to the sample range. Both channels run in lanes
// side by side and share one modulator and one tremolo phase, which start at
// a quarter turn after reset and advance by their increments once per
// accepted pair. The datapath is a six-stage pipeline (sine lookup,
// modulation multiply, drive multiply, tanh lookup, interpolation multiply,
// tremolo multiply), and one pair per cycle is taken while the output
// keeps flowing. The sine and tanh tables are constants built at
// elaboration and need no loading. Configuration registers are written
// through the cfg port; the user must write them only while no pair is in
// flight, as the block does not enforce this. Writes to an index beyond the
// last register are dropped.
`default_nettype none

module modulation_distortion_tremolo_core #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int PHASE_WIDTH     = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int TANH_TABLE_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mdt_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,  // in_left, in_right
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata   // out_left, out_right
);
  import mdt_pkg::*;

  localparam int SW      = SAMPLE_WIDTH;
  localparam int TdataW  = ((2 * SW + 7) / 8) * 8;
  localparam int Stages  = 6;

  localparam logic [PHASE_WIDTH-1:0] PhaseQuarter = {2'b01, {(PHASE_WIDTH - 2){1'b0}}};

  // configuration registers
  logic [INC_W-1:0]        mod_inc_q;
  logic [INC_W-1:0]        pulse_inc_q;
  lane_cfg_t               cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_inc_q        <= '0;
      pulse_inc_q      <= '0;
      cfg_q.mod_type   <= 1'b0;
      cfg_q.drive_en   <= 1'b0;
      cfg_q.dist_type  <= 1'b0;
      cfg_q.drive_gain <= DRIVE_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_MOD_PHASE_INC:   mod_inc_q        <= cfg_data_i[INC_W-1:0];
        REG_MOD_TYPE:        cfg_q.mod_type   <= cfg_data_i[0];
        REG_DRIVE_ENABLE:    cfg_q.drive_en   <= cfg_data_i[0];
        REG_DRIVE_GAIN:      cfg_q.drive_gain <= cfg_data_i[DRIVE_GAIN_W-1:0];
        REG_DIST_TYPE:       cfg_q.dist_type  <= cfg_data_i[0];
        REG_PULSE_PHASE_INC: pulse_inc_q      <= cfg_data_i[INC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] stage_en;
  lane_en_t          lane_en;
  logic              in_fire;

  always_comb begin
    stage_en[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  assign lane_en.s0 = stage_en[0];
  assign lane_en.s1 = stage_en[1];
  assign lane_en.s2 = stage_en[2];
  assign lane_en.s3 = stage_en[3];
  assign lane_en.s4 = stage_en[4];
  assign lane_en.s5 = stage_en[5];

  assign s_axis_tready = stage_en[0];
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // oscillator phases
  logic [PHASE_WIDTH-1:0] mod_phase_q;
  logic [PHASE_WIDTH-1:0] pulse_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_phase_q   <= PhaseQuarter;
      pulse_phase_q <= PhaseQuarter;
    end else if (in_fire) begin
      mod_phase_q   <= mod_phase_q + PHASE_WIDTH'(mod_inc_q);
      pulse_phase_q <= pulse_phase_q + PHASE_WIDTH'(pulse_inc_q);
    end
  end

  logic signed [TAB_W-1:0] msin;
  logic signed [TAB_W-1:0] psin0;
  logic signed [TAB_W-1:0] psin1_q;
  logic signed [TAB_W-1:0] psin2_q;
  logic signed [TAB_W-1:0] psin3_q;
  logic signed [TAB_W-1:0] psin4_q;

  mdt_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .en_i     (stage_en[0]),
    .addr_a_i (mod_phase_q[PHASE_WIDTH-1 -: SINE_TABLE_BITS]),
    .addr_b_i (pulse_phase_q[PHASE_WIDTH-1 -: SINE_TABLE_BITS]),
    .data_a_o (msin),
    .data_b_o (psin0)
  );

  // tremolo gain follows the pair down the pipeline
  always_ff @(posedge clk_i) begin
    if (stage_en[1]) psin1_q <= psin0;
    if (stage_en[2]) psin2_q <= psin1_q;
    if (stage_en[3]) psin3_q <= psin2_q;
    if (stage_en[4]) psin4_q <= psin3_q;
  end

  // channel lanes
  logic signed [SW-1:0] out_left;
  logic signed [SW-1:0] out_right;

  mdt_lane #(
    .SAMPLE_WIDTH    (SW),
    .TANH_TABLE_BITS (TANH_TABLE_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .cfg_i    (cfg_q),
    .sample_i ($signed(s_axis_tdata[SW-1:0])),
    .msin_i   (msin),
    .psin_i   (psin4_q),
    .sample_o (out_left)
  );

  mdt_lane #(
    .SAMPLE_WIDTH    (SW),
    .TANH_TABLE_BITS (TANH_TABLE_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .cfg_i    (cfg_q),
    .sample_i ($signed(s_axis_tdata[2*SW-1:SW])),
    .msin_i   (msin),
    .psin_i   (psin4_q),
    .sample_o (out_right)
  );

  assign m_axis_tdata = TdataW'({out_right, out_left});

endmodule

`default_nettype wire

@@ rtl/core/mdt_sine_rom.sv @@
// ----------------------------------------------------------------------------
// mdt_sine_rom
// Full-turn sine table in Q30, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [TABLE_BITS-1:0]               addr_a_i,
  input  logic [TABLE_BITS-1:0]               addr_b_i,
  output logic signed [mdt_pkg::TAB_W-1:0]    data_a_o,
  output logic signed [mdt_pkg::TAB_W-1:0]    data_b_o
);
  import mdt_pkg::*;

  localparam int Depth = 2 ** TABLE_BITS;

  logic signed [TAB_W-1:0] tab [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic signed [TAB_W-1:0] Value = sine_entry(g, TABLE_BITS);
    assign tab[g] = Value;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= tab[addr_a_i];
      data_b_o <= tab[addr_b_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mdt_tanh_rom.sv @@
// ----------------------------------------------------------------------------
// mdt_tanh_rom
// Tanh table over 0 to 8.0 in Q30, two registered read ports for
// neighboring entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_tanh_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [TABLE_BITS:0]                 addr_a_i,
  input  logic [TABLE_BITS:0]                 addr_b_i,
  output logic signed [mdt_pkg::TAB_W-1:0]    data_a_o,
  output logic signed [mdt_pkg::TAB_W-1:0]    data_b_o
);
  import mdt_pkg::*;

  localparam int Depth = 2 ** TABLE_BITS + 1;

  logic signed [TAB_W-1:0] tab [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic signed [TAB_W-1:0] Value = tanh_entry(g, TABLE_BITS);
    assign tab[g] = Value;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= tab[addr_a_i];
      data_b_o <= tab[addr_b_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mdt_lane.sv @@
// ----------------------------------------------------------------------------
// mdt_lane
// One channel: modulation, drive with soft or hard clip, tremolo and
// output saturation, in six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_lane #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int TANH_TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  mdt_pkg::lane_en_t                 en_i,
  input  mdt_pkg::lane_cfg_t                cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic signed [mdt_pkg::TAB_W-1:0]  msin_i,
  input  logic signed [mdt_pkg::TAB_W-1:0]  psin_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_o
);
  import mdt_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TB   = TANH_TABLE_BITS;
  localparam int MW   = SW + 1;
  localparam int DW   = SW + 11;
  localparam int FRAC = SW + 2 - TB;
  localparam int PMW  = SW + 33;
  localparam int PDW  = SW + 27;
  localparam int PIW  = TAB_W + FRAC + 1;
  localparam int PPW  = SW + 34;

  localparam logic signed [32:0]    OneQ30 = 33'sd1073741824;
  localparam logic signed [PMW-1:0] RndM   = 1 <<< 30;
  localparam logic signed [PDW-1:0] RndD   = 1 <<< 15;
  localparam logic signed [PIW-1:0] RndI   = 1 <<< (FRAC - 1);
  localparam logic signed [PPW-1:0] RndP   = 1 <<< 30;
  localparam logic signed [DW-1:0]  LimP   = {{(DW - SW){1'b0}}, 1'b1, {(SW - 1){1'b0}}};
  localparam logic signed [DW-1:0]  LimN   = -LimP;
  localparam logic signed [TAB_W-1:0] TanhLast = tanh_entry(2 ** TB, TB);

  // stage registers
  logic signed [SW-1:0]    s0_q;
  logic signed [MW-1:0]    v1_q;
  logic signed [DW-1:0]    d2_q;
  logic signed [MW-1:0]    byp2_q;
  logic                    big3_q;
  logic                    neg3_q;
  logic                    soft3_q;
  logic [FRAC-1:0]         fr3_q;
  logic signed [MW-1:0]    direct3_q;
  logic signed [TAB_W-1:0] t4_q;
  logic                    neg4_q;
  logic                    soft4_q;
  logic signed [MW-1:0]    direct4_q;
  logic signed [SW-1:0]    y5_q;

  // modulation
  logic signed [32:0]      gain_m;
  logic signed [PMW-1:0]   prod_m;
  logic signed [PMW-1:0]   rnd_m;

  always_comb begin
    gain_m = cfg_i.mod_type ? $signed({msin_i, 1'b0}) : ($signed({msin_i[TAB_W-1], msin_i}) + OneQ30);
    prod_m = s0_q * gain_m;
    rnd_m  = (prod_m + RndM) >>> 31;
  end

  // drive
  logic signed [PDW-1:0]   prod_d;
  logic signed [PDW-1:0]   rnd_d;

  always_comb begin
    prod_d = v1_q * $signed({1'b0, cfg_i.drive_gain});
    rnd_d  = (prod_d + RndD) >>> 16;
  end

  // tanh lookup and hard clip
  logic [DW-1:0]           mag;
  logic [TB:0]             tanh_addr;
  logic signed [DW-1:0]    hard_full;
  logic signed [TAB_W-1:0] t0;
  logic signed [TAB_W-1:0] t1;

  always_comb begin
    mag       = d2_q[DW-1] ? $unsigned(-d2_q) : $unsigned(d2_q);
    tanh_addr = {1'b0, mag[SW+1:FRAC]};
    if (d2_q > LimP) begin
      hard_full = LimP;
    end else if (d2_q < LimN) begin
      hard_full = LimN;
    end else begin
      hard_full = d2_q;
    end
  end

  mdt_tanh_rom #(
    .TABLE_BITS (TB)
  ) u_tanh_rom (
    .clk_i    (clk_i),
    .en_i     (en_i.s3),
    .addr_a_i (tanh_addr),
    .addr_b_i (tanh_addr + 1'b1),
    .data_a_o (t0),
    .data_b_o (t1)
  );

  // interpolation
  logic signed [TAB_W-1:0] diff;
  logic signed [PIW-1:0]   prod_i;
  logic signed [PIW-1:0]   rnd_i;

  always_comb begin
    diff   = t1 - t0;
    prod_i = diff * $signed({1'b0, fr3_q});
    rnd_i  = (prod_i + RndI) >>> FRAC;
  end

  // rescale to sample format
  logic signed [MW-1:0]    soft_mag;

  if (SW <= 30) begin : g_rescale_shift
    localparam int Sh = 31 - SW;
    localparam logic signed [32:0] RndS = 33'sd1 <<< (Sh - 1);
    logic signed [32:0] t_rs;
    assign t_rs     = ($signed({t4_q[TAB_W-1], t4_q}) + RndS) >>> Sh;
    assign soft_mag = t_rs[MW-1:0];
  end else if (SW == 31) begin : g_rescale_same
    assign soft_mag = t4_q;
  end else begin : g_rescale_double
    assign soft_mag = $signed({t4_q, 1'b0});
  end

  // tremolo and saturation
  logic signed [MW-1:0]    s5;
  logic signed [32:0]      gain_p;
  logic signed [PPW-1:0]   prod_p;
  logic signed [PPW-1:0]   rnd_p;
  logic [PPW-SW:0]         rnd_hi;
  logic signed [SW-1:0]    y5_d;

  always_comb begin
    if (soft4_q) begin
      s5 = neg4_q ? -soft_mag : soft_mag;
    end else begin
      s5 = direct4_q;
    end
    gain_p = $signed({psin_i[TAB_W-1], psin_i}) + OneQ30;
    prod_p = s5 * gain_p;
    rnd_p  = (prod_p + RndP) >>> 31;
    rnd_hi = rnd_p[PPW-1:SW-1];
    if ((&rnd_hi) || !(|rnd_hi)) begin
      y5_d = rnd_p[SW-1:0];
    end else if (rnd_p[PPW-1]) begin
      y5_d = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      y5_d = {1'b0, {(SW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      s0_q <= sample_i;
    end
    if (en_i.s1) begin
      v1_q <= rnd_m[MW-1:0];
    end
    if (en_i.s2) begin
      d2_q   <= rnd_d[DW-1:0];
      byp2_q <= v1_q;
    end
    if (en_i.s3) begin
      big3_q    <= |mag[DW-1:SW+2];
      neg3_q    <= d2_q[DW-1];
      soft3_q   <= cfg_i.drive_en && !cfg_i.dist_type;
      fr3_q     <= mag[FRAC-1:0];
      direct3_q <= cfg_i.drive_en ? hard_full[MW-1:0] : byp2_q;
    end
    if (en_i.s4) begin
      t4_q      <= big3_q ? TanhLast : (t0 + rnd_i[TAB_W-1:0]);
      neg4_q    <= neg3_q;
      soft4_q   <= soft3_q;
      direct4_q <= direct3_q;
    end
    if (en_i.s5) begin
      y5_q <= y5_d;
    end
  end

  assign sample_o = y5_q;

endmodule

`default_nettype wire
